### rtl/core/pms_pkg.sv
package pms_pkg;

	localparam int MAX_USERS = 64;
	localparam int IDX_W = $clog2(MAX_USERS);
	localparam int CNT_W = $clog2(MAX_USERS + 1);
	localparam int TIME_W = 48;
	localparam int ID_W = 16;
	localparam int PER_W = 16;

	localparam logic [1:0] OP_REG = 2'd0;
	localparam logic [1:0] OP_NEXT = 2'd1;
	localparam logic [1:0] OP_CLR = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic load;
		logic clr;
		logic wr_new;
		logic scan_rd;
		logic scan_cmp;
		logic fin_next;
		logic wr_adv;
		logic done;
		logic [1:0] st;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_last;
	} sts_t;

endpackage

### rtl/core/pms_datapath.sv
module pms_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  pms_pkg::cmd_t                    cmd,
	output pms_pkg::sts_t                    sts,
	input  logic [pms_pkg::ID_W-1:0]         user_id,
	input  logic [pms_pkg::PER_W-1:0]        period,
	output logic [pms_pkg::ID_W-1:0]         served_id,
	output logic [pms_pkg::TIME_W-1:0]       due_time,
	output logic [1:0]                       status,
	output logic                             done
);
	localparam int ENT_W = pms_pkg::ID_W + pms_pkg::PER_W + pms_pkg::TIME_W;

	logic [ENT_W-1:0] mem_q [pms_pkg::MAX_USERS];
	logic [ENT_W-1:0] rd_q;
	logic [pms_pkg::CNT_W-1:0] count_q;
	logic [pms_pkg::IDX_W-1:0] rd_idx_q, cmp_idx_q, best_idx_q;
	logic [pms_pkg::ID_W-1:0] uid_q, best_id_q;
	logic [pms_pkg::PER_W-1:0] per_q, best_per_q;
	logic [pms_pkg::TIME_W-1:0] best_due_q;
	logic have_q;
	logic done_q;
	logic [pms_pkg::ID_W-1:0] sid_q;
	logic [pms_pkg::TIME_W-1:0] due_q;
	logic [1:0] st_q;

	logic [pms_pkg::ID_W-1:0] r_id;
	logic [pms_pkg::PER_W-1:0] r_per;
	logic [pms_pkg::TIME_W-1:0] r_due;
	logic better;
	logic [pms_pkg::TIME_W:0] sum;
	logic [pms_pkg::TIME_W-1:0] adv;
	logic [pms_pkg::IDX_W-1:0] wr_idx;
	logic [ENT_W-1:0] wr_data;
	logic wr_en;

	assign r_id = rd_q[ENT_W-1 -: pms_pkg::ID_W];
	assign r_per = rd_q[pms_pkg::TIME_W +: pms_pkg::PER_W];
	assign r_due = rd_q[pms_pkg::TIME_W-1:0];
	assign better = !have_q || (r_due < best_due_q) ||
		((r_due == best_due_q) && (r_id < best_id_q));
	assign sum = {1'b0, best_due_q} + {{(pms_pkg::TIME_W+1-pms_pkg::PER_W){1'b0}}, best_per_q};
	assign adv = sum[pms_pkg::TIME_W] ? {pms_pkg::TIME_W{1'b1}} : sum[pms_pkg::TIME_W-1:0];

	assign sts.full = (count_q == pms_pkg::CNT_W'(pms_pkg::MAX_USERS));
	assign sts.empty = (count_q == '0);
	assign sts.scan_last = ({1'b0, rd_idx_q} == (count_q - 1'b1));

	always_comb begin
		wr_en = cmd.wr_new || cmd.wr_adv;
		wr_idx = cmd.wr_adv ? best_idx_q : count_q[pms_pkg::IDX_W-1:0];
		wr_data = cmd.wr_adv ? {best_id_q, best_per_q, adv} :
			{uid_q, per_q, {(pms_pkg::TIME_W-pms_pkg::PER_W){1'b0}}, per_q};
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_idx] <= wr_data;
		rd_q <= mem_q[rd_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q <= 1'b0;
			have_q <= 1'b0;
		end else begin
			done_q <= cmd.done;
			if (cmd.clr)
				count_q <= '0;
			else if (cmd.wr_new)
				count_q <= count_q + 1'b1;
			if (cmd.load)
				have_q <= 1'b0;
			else if (cmd.scan_cmp && better)
				have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			uid_q <= user_id;
			per_q <= period;
			rd_idx_q <= '0;
		end else if (cmd.scan_rd) begin
			rd_idx_q <= rd_idx_q + 1'b1;
		end
		if (cmd.scan_rd)
			cmp_idx_q <= rd_idx_q;
		if (cmd.scan_cmp && better) begin
			best_idx_q <= cmp_idx_q;
			best_id_q <= r_id;
			best_per_q <= r_per;
			best_due_q <= r_due;
		end
		if (cmd.done) begin
			st_q <= cmd.st;
			sid_q <= cmd.fin_next ? best_id_q : '0;
			due_q <= cmd.fin_next ? best_due_q : '0;
		end
	end

	assign served_id = sid_q;
	assign due_time = due_q;
	assign status = st_q;
	assign done = done_q;
endmodule

### rtl/core/pms_ctrl.sv
module pms_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [1:0]    op,
	input  pms_pkg::sts_t sts,
	output pms_pkg::cmd_t cmd,
	output logic          busy
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_LAST = 3'd3;
	localparam logic [2:0] S_WB   = 3'd4;
	localparam logic [2:0] S_OUT  = 3'd5;

	logic [2:0] state_q, state_d;
	logic [1:0] op_q;
	logic rd_last_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				priority if (op_q == pms_pkg::OP_REG) begin
					cmd.done = 1'b1;
					if (sts.full)
						cmd.st = pms_pkg::ST_FULL;
					else
						cmd.wr_new = 1'b1;
					state_d = S_OUT;
				end else if (op_q == pms_pkg::OP_NEXT) begin
					if (sts.empty) begin
						cmd.done = 1'b1;
						cmd.st = pms_pkg::ST_EMPTY;
						state_d = S_OUT;
					end else begin
						state_d = S_RD;
					end
				end else begin
					cmd.clr = (op_q == pms_pkg::OP_CLR);
					cmd.done = 1'b1;
					state_d = S_OUT;
				end
			end
			S_RD: begin
				cmd.scan_rd = 1'b1;
				if (rd_last_q)
					cmd.scan_cmp = 1'b1;
				if (sts.scan_last)
					state_d = S_LAST;
			end
			S_LAST: begin
				cmd.scan_cmp = 1'b1;
				state_d = S_WB;
			end
			S_WB: begin
				cmd.wr_adv = 1'b1;
				cmd.fin_next = 1'b1;
				cmd.done = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= pms_pkg::OP_REG;
			rd_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load)
				op_q <= op;
			rd_last_q <= (state_q == S_RD);
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule

### rtl/core/periodic_message_scheduler_top.sv
// Register, clear and failed next decide in the decode state and return the result.
// Next scans every table entry, then writes back the chosen entry's advanced due time.
// A new request is taken only when idle; busy stays high through the result strobe cycle.
// Reset: arst_n clears the controller and the user count; table memory is not cleared.
// The receiver cannot stall: done marks the result for one cycle.
module periodic_message_scheduler_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [15:0] user_id,
	input  logic [15:0] period,
	output logic        done,
	output logic [15:0] served_id,
	output logic [47:0] due_time,
	output logic [1:0]  status
);
	pms_pkg::cmd_t cmd;
	pms_pkg::sts_t sts;

	pms_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	pms_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.user_id(user_id), .period(period), .served_id(served_id),
		.due_time(due_time), .status(status), .done(done)
	);

`ifndef ASSERT_OFF
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without request");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");
`endif
endmodule
